// ----- sv/utf8sa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sa_pkg
// Shared types, codes and decode helpers for the UTF-8 sequence assembler.
// ----------------------------------------------------------------------------
package utf8sa_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 3;
    localparam int OUT_DATA_W = 40;  // 3 + 4*8 = 35 bits, padded to whole bytes

    localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

    // Pending sequence state: sequence length and continuation bytes still owed
    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_2B_1  = 4'd1,
        ST_3B_2  = 4'd2,
        ST_3B_1  = 4'd3,
        ST_4B_3  = 4'd4,
        ST_4B_2  = 4'd5,
        ST_4B_1  = 4'd6,
        ST_5B_4  = 4'd7,
        ST_5B_3  = 4'd8,
        ST_5B_2  = 4'd9,
        ST_5B_1  = 4'd10,
        ST_6B_5  = 4'd11,
        ST_6B_4  = 4'd12,
        ST_6B_3  = 4'd13,
        ST_6B_2  = 4'd14,
        ST_6B_1  = 4'd15
    } pend_state_t;

    // One registered input word handed from the input stage to the framer
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } in_word_t;

    // State entered on a lead byte (0xC0..0xFF); idle for 0xFE and 0xFF
    function automatic pend_state_t lead_state(input logic [BYTE_W-1:0] c);
        pend_state_t s;
        if ((c & 8'he0) == 8'hc0) begin
            s = ST_2B_1;
        end else if ((c & 8'hf0) == 8'he0) begin
            s = ST_3B_2;
        end else if ((c & 8'hf8) == 8'hf0) begin
            s = ST_4B_3;
        end else if ((c & 8'hfc) == 8'hf8) begin
            s = ST_5B_4;
        end else if ((c & 8'hfe) == 8'hfc) begin
            s = ST_6B_5;
        end else begin
            s = ST_IDLE;
        end
        return s;
    endfunction

endpackage

// ----- sv/utf8sa_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sa_in_stage
// Input register: captures one byte word and holds it until the framer takes it.
// ----------------------------------------------------------------------------
module utf8sa_in_stage
    import utf8sa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    input  logic              take,
    output in_word_t          word
);

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] data_reg, data_next;

    // Accept whenever the register is empty or drains this cycle
    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
            if (s_tvalid) begin
                data_next = s_tdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign word.valid = valid_reg;
    assign word.data  = data_reg;

endmodule

// ----- sv/utf8sa_framer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sa_framer
// Sequence state, held bytes and the result register of the assembler.
// ----------------------------------------------------------------------------
module utf8sa_framer
    import utf8sa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  in_word_t              word,
    output logic                  take,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    pend_state_t       state_reg, state_next;
    logic [BYTE_W-1:0] held0_reg, held0_next;
    logic [BYTE_W-1:0] held1_reg, held1_next;
    logic [BYTE_W-1:0] held2_reg, held2_next;

    logic              out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic [BYTE_W-1:0] out_b0_reg, out_b0_next;
    logic [BYTE_W-1:0] out_b1_reg, out_b1_next;
    logic [BYTE_W-1:0] out_b2_reg, out_b2_next;
    logic [BYTE_W-1:0] out_b3_reg, out_b3_next;

    logic              emit;
    logic [LEN_W-1:0]  res_len;
    logic [BYTE_W-1:0] res_b0, res_b1, res_b2, res_b3;

    logic [BYTE_W-1:0] c;
    logic              is_ascii, is_cont;

    assign c        = word.data;
    assign is_ascii = !c[7];
    assign is_cont  = (c[7:6] == 2'b10);

    // Take the input word when the result register is free or drains now
    assign take = word.valid && (!out_valid_reg || m_tready);

    // Next state
    always_comb begin
        state_next = state_reg;
        if (take) begin
            if (is_ascii) begin
                state_next = ST_IDLE;
            end else if (!is_cont) begin
                state_next = lead_state(c);
            end else begin
                unique case (state_reg)
                    ST_IDLE: state_next = ST_IDLE;
                    ST_2B_1: state_next = ST_IDLE;
                    ST_3B_2: state_next = ST_3B_1;
                    ST_3B_1: state_next = ST_IDLE;
                    ST_4B_3: state_next = ST_4B_2;
                    ST_4B_2: state_next = ST_4B_1;
                    ST_4B_1: state_next = ST_IDLE;
                    ST_5B_4: state_next = ST_5B_3;
                    ST_5B_3: state_next = ST_5B_2;
                    ST_5B_2: state_next = ST_5B_1;
                    ST_5B_1: state_next = ST_IDLE;
                    ST_6B_5: state_next = ST_6B_4;
                    ST_6B_4: state_next = ST_6B_3;
                    ST_6B_3: state_next = ST_6B_2;
                    ST_6B_2: state_next = ST_6B_1;
                    ST_6B_1: state_next = ST_IDLE;
                    default: state_next = ST_IDLE;
                endcase
            end
        end
    end

    // Result and held-byte updates
    always_comb begin
        emit       = 1'b0;
        res_len    = LEN_1;
        res_b0     = c;
        res_b1     = '0;
        res_b2     = '0;
        res_b3     = '0;
        held0_next = held0_reg;
        held1_next = held1_reg;
        held2_next = held2_reg;
        if (take) begin
            if (is_ascii) begin
                emit = 1'b1;
            end else if (!is_cont) begin
                if (c[7:1] == 7'h7f) begin
                    emit = 1'b1;
                end else if (c[7:3] != 5'b11111) begin
                    held0_next = c;
                end
            end else begin
                unique case (state_reg)
                    ST_2B_1: begin
                        emit    = 1'b1;
                        res_len = LEN_2;
                        res_b0  = held0_reg;
                        res_b1  = c;
                    end
                    ST_3B_2: held1_next = c;
                    ST_3B_1: begin
                        emit    = 1'b1;
                        res_len = LEN_3;
                        res_b0  = held0_reg;
                        res_b1  = held1_reg;
                        res_b2  = c;
                    end
                    ST_4B_3: held1_next = c;
                    ST_4B_2: held2_next = c;
                    ST_4B_1: begin
                        emit    = 1'b1;
                        res_len = LEN_4;
                        res_b0  = held0_reg;
                        res_b1  = held1_reg;
                        res_b2  = held2_reg;
                        res_b3  = c;
                    end
                    default: emit = 1'b0;
                endcase
            end
        end
    end

    // Result register: load on emit, drop on handoff
    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_len_next   = out_len_reg;
        out_b0_next    = out_b0_reg;
        out_b1_next    = out_b1_reg;
        out_b2_next    = out_b2_reg;
        out_b3_next    = out_b3_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_len_next   = res_len;
            out_b0_next    = res_b0;
            out_b1_next    = res_b1;
            out_b2_next    = res_b2;
            out_b3_next    = res_b3;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        held0_reg   <= held0_next;
        held1_reg   <= held1_next;
        held2_reg   <= held2_next;
        out_len_reg <= out_len_next;
        out_b0_reg  <= out_b0_next;
        out_b1_reg  <= out_b1_next;
        out_b2_reg  <= out_b2_next;
        out_b3_reg  <= out_b3_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_b3_reg, out_b2_reg, out_b1_reg, out_b0_reg, out_len_reg};

`ifndef SYNTHESIS
    a_ascii_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !word.data[7] |=> m_tvalid && out_len_reg == LEN_1 && state_reg == ST_IDLE)
        else $error("ASCII word did not produce a single-byte result");

    a_two_byte_done: assert property (@(posedge aclk) disable iff (!aresetn)
        take && word.data[7:6] == 2'b10 && state_reg == ST_2B_1
        |=> m_tvalid && out_len_reg == LEN_2 && state_reg == ST_IDLE)
        else $error("two-byte sequence did not complete");

    a_stray_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        take && word.data[7:6] == 2'b10 && state_reg == ST_IDLE |-> !emit)
        else $error("stray continuation produced a result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !take)
        else $error("stalled result register was overwritten");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_len_reg == LEN_1 || out_len_reg == LEN_2
                  || out_len_reg == LEN_3 || out_len_reg == LEN_4)
        else $error("result length out of range");
`endif

endmodule

// ----- sv/utf8_sequence_assembler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_sequence_assembler
// Frames a raw UTF-8 byte stream into whole character sequences.
// ----------------------------------------------------------------------------
// One byte enters per word on the slave side; complete sequences leave on the
// master side with their length and up to four bytes, unused bytes zero.
// ASCII bytes (zero included) and the bytes 0xFE and 0xFF leave alone. A
// stray continuation byte while idle is dropped. A lead byte that arrives
// while a sequence is pending abandons it and starts over; an ASCII byte
// abandons it and is sent alone. Five and six byte sequences are parsed and
// discarded without a result. Rate: one byte per cycle while the master side
// takes each result. Each byte is held in the input register and is then
// decoded in a single pass against the pending state; a finished sequence is
// registered in the result register before it appears on the master side.
// Throughput is limited only by master-side backpressure: the single result
// register stalls the input register while a result waits to be taken.
module utf8_sequence_assembler
    import utf8sa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] in_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] seq_len, [10:3] seq_byte0, [18:11] seq_byte1,
    // [26:19] seq_byte2, [34:27] seq_byte3, [39:35] zero
    output logic [OUT_DATA_W-1:0] m_tdata
);

    in_word_t word;
    logic     take;

    // Hold the incoming byte until the framer can take it
    utf8sa_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .word     (word)
    );

    // Advance the sequence state and register any finished sequence
    utf8sa_framer u_framer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .word     (word),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
